[design/ssf_pkg.sv]
// Package for the sieve semiprime factorizer.
// Holds the default sizes, the field widths and the divider result type.
// Used by ssf_divider and sieve_semiprime_factorizer; depends on nothing.
package ssf_pkg;

    // Default sizes of the sieve map and of the survivor list.
    localparam int unsigned DEFAULT_MAX_N      = 65536;
    localparam int unsigned DEFAULT_LIST_DEPTH = 8192;

    // Fixed widths of the stream fields.
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned IDX_W    = 13;
    localparam int unsigned COUNT_W  = 14;
    localparam int unsigned OUT_W    = 1 + 2 * VAL_W + 2 * IDX_W + COUNT_W;
    localparam int unsigned M_DATA_W = ((OUT_W + 7) / 8) * 8;

    // Status and results of the iterative divider.
    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quotient;
        logic [VAL_W-1:0] remainder;
    } div_res_t;

endpackage

[design/sieve_semiprime_factorizer.sv]
// Top level of the sieve semiprime factorizer: sieve, survivor list and pair search.
// Depends on ssf_pkg and instantiates ssf_divider.
//
// Usage: each word on the slave channel (s_tdata) carries a modulus n. The block
// clears a one-bit composite map over the values below min(n, MAX_N), strikes out
// the multiples of every survivor from 2 up, lists the survivors (1 and the
// primes) in a second memory, and then walks the list for the first entry a
// that divides n and whose partner n / a is also listed (found by binary search).
// Exactly one result word leaves on the master channel per modulus.
// Run time depends on the data: the block clears the map, reads each value and
// writes each struck multiple for the sieve, reads each value again to build the
// list, then reads each list entry, tests it with the divider and, if it divides
// n, takes binary search steps; each memory has a single port throughout.
// One modulus is worked on at a time: s_tready is high only while idle. A
// finished result sits in the output register until the receiver takes it; a
// new modulus is accepted meanwhile, and the block only waits at the end of that
// next item if the first result is still held. Reset empties the output
// register and returns to idle; the memories need no clearing after reset.
module sieve_semiprime_factorizer #(
    parameter int unsigned MAX_N      = ssf_pkg::DEFAULT_MAX_N,
    parameter int unsigned LIST_DEPTH = ssf_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: modulus [15:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ssf_pkg::VAL_W-1:0]     s_tdata,
    // m_tdata: found [0], factor_small [16:1], factor_large [32:17],
    // index_small [45:33], index_large [58:46], list_count [72:59], zeros above
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ssf_pkg::M_DATA_W-1:0]  m_tdata
);
    localparam int unsigned VW = ssf_pkg::VAL_W;
    localparam int unsigned LW = VW + 1;                  // value counters, one spare bit
    localparam int unsigned AW = $clog2(MAX_N);           // map address
    localparam int unsigned IW = $clog2(LIST_DEPTH);      // list address
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);  // list count
    localparam int unsigned PADW = ssf_pkg::M_DATA_W - ssf_pkg::OUT_W;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CLEAR  = 13'b0000000000010,
        ST_SV_RD  = 13'b0000000000100,
        ST_SV_CHK = 13'b0000000001000,
        ST_MARK   = 13'b0000000010000,
        ST_L_RD   = 13'b0000000100000,
        ST_L_CHK  = 13'b0000001000000,
        ST_P_RD   = 13'b0000010000000,
        ST_P_CHK  = 13'b0000100000000,
        ST_DIV    = 13'b0001000000000,
        ST_B_RD   = 13'b0010000000000,
        ST_B_CHK  = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [VW-1:0]   n_reg, n_next;
    logic [LW-1:0]   lim_reg, lim_next;
    logic [LW-1:0]   v_reg, v_next;
    logic [LW-1:0]   m_reg, m_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   p_reg, p_next;
    logic [VW-1:0]   a_reg, a_next;
    logic [VW-1:0]   b_reg, b_next;
    logic [CW-1:0]   lo_reg, lo_next;
    logic [CW-1:0]   hi_reg, hi_next;
    logic [IW-1:0]   mid_reg, mid_next;
    logic            found_reg, found_next;
    logic [VW-1:0]   fs_reg, fs_next;
    logic [VW-1:0]   fl_reg, fl_next;
    logic [CW-1:0]   is_reg, is_next;
    logic [CW-1:0]   il_reg, il_next;

    logic                          out_valid_reg, out_valid_next;
    logic [ssf_pkg::M_DATA_W-1:0]  out_data_reg, out_data_next;

    // Composite map: one bit per value, single port, registered read.
    logic            map_mem [MAX_N];
    logic            map_we, map_wdata, map_re;
    logic [AW-1:0]   map_waddr, map_raddr;
    logic            map_rd_reg;

    // Survivor list: one value per entry, single port, registered read.
    logic [VW-1:0]   list_mem [LIST_DEPTH];
    logic            list_we, list_re;
    logic [IW-1:0]   list_waddr, list_raddr;
    logic [VW-1:0]   list_rd_reg;

    logic              div_start;
    ssf_pkg::div_res_t div_res;
    logic [CW-1:0]     mid_full;
    logic [LW-1:0]     lim_calc;
    logic              out_load;

    // The divisor is taken as it is loaded into a_reg, so the divider and
    // a_reg pick up the same list entry at the same edge.
    ssf_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (a_next),
        .res      (div_res)
    );

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= v_reg[VW-1:0];
        end
        if (list_re) begin
            list_rd_reg <= list_mem[list_raddr];
        end
    end

    // The sieve covers the values below min(n, MAX_N).
    assign lim_calc = (32'(s_tdata) < MAX_N) ? {1'b0, s_tdata} : LW'(MAX_N);
    assign mid_full = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        lim_next   = lim_reg;
        v_next     = v_reg;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        p_next     = p_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        fs_next    = fs_reg;
        fl_next    = fl_reg;
        is_next    = is_reg;
        il_next    = il_reg;
        map_we     = 1'b0;
        map_wdata  = 1'b0;
        map_waddr  = AW'(v_reg);
        map_re     = 1'b0;
        map_raddr  = AW'(v_reg);
        list_we    = 1'b0;
        list_waddr = cnt_reg[IW-1:0];
        list_re    = 1'b0;
        list_raddr = p_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next     = s_tdata;
                    lim_next   = lim_calc;
                    v_next     = '0;
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                // Value 0 is struck out, everything else starts as a survivor.
                if (v_reg < lim_reg) begin
                    map_we    = 1'b1;
                    map_wdata = (v_reg == '0);
                    v_next    = v_reg + LW'(1);
                end else begin
                    v_next     = LW'(2);
                    state_next = ST_SV_RD;
                end
            end
            ST_SV_RD: begin
                if (v_reg < lim_reg) begin
                    map_re     = 1'b1;
                    state_next = ST_SV_CHK;
                end else begin
                    v_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_L_RD;
                end
            end
            ST_SV_CHK: begin
                if (!map_rd_reg) begin
                    m_next     = v_reg + v_reg;
                    state_next = ST_MARK;
                end else begin
                    v_next     = v_reg + LW'(1);
                    state_next = ST_SV_RD;
                end
            end
            ST_MARK: begin
                if (m_reg < lim_reg) begin
                    map_we    = 1'b1;
                    map_wdata = 1'b1;
                    map_waddr = AW'(m_reg);
                    m_next    = m_reg + v_reg;
                end else begin
                    v_next     = v_reg + LW'(1);
                    state_next = ST_SV_RD;
                end
            end
            ST_L_RD: begin
                if (v_reg < lim_reg && cnt_reg < CW'(LIST_DEPTH)) begin
                    map_re     = 1'b1;
                    state_next = ST_L_CHK;
                end else begin
                    p_next     = '0;
                    state_next = ST_P_RD;
                end
            end
            ST_L_CHK: begin
                if (!map_rd_reg) begin
                    list_we  = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                v_next     = v_reg + LW'(1);
                state_next = ST_L_RD;
            end
            ST_P_RD: begin
                if (p_reg < cnt_reg) begin
                    list_re    = 1'b1;
                    state_next = ST_P_CHK;
                end else begin
                    found_next = 1'b0;
                    fs_next    = '0;
                    fl_next    = '0;
                    is_next    = '0;
                    il_next    = '0;
                    state_next = ST_DONE;
                end
            end
            ST_P_CHK: begin
                a_next = list_rd_reg;
                if (list_rd_reg == '0) begin
                    p_next     = p_reg + CW'(1);
                    state_next = ST_P_RD;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // The divider was started as this state was entered; wait for its result.
                if (div_res.done) begin
                    if (div_res.remainder != '0) begin
                        p_next     = p_reg + CW'(1);
                        state_next = ST_P_RD;
                    end else begin
                        b_next     = div_res.quotient;
                        lo_next    = '0;
                        hi_next    = cnt_reg;
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_B_RD: begin
                if (lo_reg < hi_reg) begin
                    list_re    = 1'b1;
                    list_raddr = mid_full[IW-1:0];
                    mid_next   = mid_full[IW-1:0];
                    state_next = ST_B_CHK;
                end else begin
                    p_next     = p_reg + CW'(1);
                    state_next = ST_P_RD;
                end
            end
            ST_B_CHK: begin
                if (list_rd_reg == b_reg) begin
                    found_next = 1'b1;
                    fs_next    = a_reg;
                    fl_next    = b_reg;
                    is_next    = p_reg;
                    il_next    = CW'(mid_reg);
                    state_next = ST_DONE;
                end else if (list_rd_reg < b_reg) begin
                    lo_next    = CW'(mid_reg) + CW'(1);
                    state_next = ST_B_RD;
                end else begin
                    hi_next    = CW'(mid_reg);
                    state_next = ST_B_RD;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The divider starts on entry to ST_DIV.
        div_start = (state_reg == ST_P_CHK) && (list_rd_reg != '0);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = {{PADW{1'b0}}, ssf_pkg::COUNT_W'(cnt_reg),
                              ssf_pkg::IDX_W'(il_reg), ssf_pkg::IDX_W'(is_reg),
                              fl_reg, fs_reg, found_reg};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg        <= n_next;
        lim_reg      <= lim_next;
        v_reg        <= v_next;
        m_reg        <= m_next;
        cnt_reg      <= cnt_next;
        p_reg        <= p_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        found_reg    <= found_next;
        fs_reg       <= fs_next;
        fl_reg       <= fl_next;
        is_reg       <= is_next;
        il_reg       <= il_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // The list never grows past its memory.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_L_CHK) |-> (cnt_reg < CW'(LIST_DEPTH)))
        else $error("survivor count overran the list memory");

    // The binary search only probes entries that were listed for this modulus.
    a_mid_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_CHK) |-> (CW'(mid_reg) < cnt_reg))
        else $error("binary search read beyond the listed survivors");

    // A reported pair multiplies exactly to the modulus.
    a_pair_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && found_reg) |->
            (32'(fs_reg) * 32'(fl_reg) == 32'(n_reg)))
        else $error("reported factors do not multiply to the modulus");

    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (state_reg == ST_DIV && a_reg != '0))
        else $error("divider started without a nonzero divisor");
`endif

endmodule

[design/ssf_divider.sv]
// Restoring divider for the sieve semiprime factorizer, one quotient bit a cycle.
// Depends on ssf_pkg for the operand width and the result type.
module ssf_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ssf_pkg::VAL_W-1:0]      dividend,
    input  logic [ssf_pkg::VAL_W-1:0]      divisor,
    output ssf_pkg::div_res_t              res
);
    localparam int unsigned W  = ssf_pkg::VAL_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0]    shifted;
    logic [W+1:0]  diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Keep the trial difference only when it did not go negative.
            if (!diff[W+1]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

[verif/sieve_semiprime_factorizer_tb.sv]
// Testbench for sieve_semiprime_factorizer: a directed table, then random moduli, with
// random idling on both stream sides. Depends on ssf_pkg and the design sources.
// Each result word is checked field by field against a sieve-and-search predictor.
`timescale 1ns / 1ps

module sieve_semiprime_factorizer_tb;

    localparam int unsigned SIEVE_SIZE = ssf_pkg::DEFAULT_MAX_N;
    localparam int unsigned LIST_SIZE  = ssf_pkg::DEFAULT_LIST_DEPTH;
    localparam int unsigned DIR_ROWS   = 22;
    localparam int unsigned RAND_ITEMS = 80;
    // Watchdog time for the whole run, well above the slowest correct run.
    localparam longint      TIMEOUT_NS = 64'd1_000_000_000;

    // One decoded result word, in the order of the m_tdata fields.
    typedef struct packed {
        logic                        found;
        logic [ssf_pkg::VAL_W-1:0]   factor_small;
        logic [ssf_pkg::VAL_W-1:0]   factor_large;
        logic [ssf_pkg::IDX_W-1:0]   index_small;
        logic [ssf_pkg::IDX_W-1:0]   index_large;
        logic [ssf_pkg::COUNT_W-1:0] list_count;
    } factor_result_t;

    // A row of the directed table. When has_answer is set the answer is typed in,
    // otherwise the predictor supplies it.
    typedef struct packed {
        logic           has_answer;
        logic [15:0]    modulus;
        factor_result_t answer;
    } stim_row_t;

    localparam int unsigned RES_W = $bits(factor_result_t);

    // Directed moduli: tiny cases with no list or a list of 1 only, the smallest
    // squares and semiprimes, primes, plain composites and both ends of the range.
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        {1'b1, 16'd0,     1'b0, 16'd0, 16'd0, 13'd0, 13'd0, 14'd0},
        {1'b1, 16'd1,     1'b0, 16'd0, 16'd0, 13'd0, 13'd0, 14'd0},
        {1'b1, 16'd2,     1'b0, 16'd0, 16'd0, 13'd0, 13'd0, 14'd1},
        {1'b1, 16'd3,     1'b0, 16'd0, 16'd0, 13'd0, 13'd0, 14'd2},
        {1'b1, 16'd4,     1'b1, 16'd2, 16'd2, 13'd1, 13'd1, 14'd3},
        {1'b1, 16'd6,     1'b1, 16'd2, 16'd3, 13'd1, 13'd2, 14'd4},
        {1'b1, 16'd9,     1'b1, 16'd3, 16'd3, 13'd2, 13'd2, 14'd5},
        {1'b1, 16'd15,    1'b1, 16'd3, 16'd5, 13'd2, 13'd3, 14'd7},
        {1'b0, 16'd5,     {RES_W{1'b0}}},
        {1'b0, 16'd7,     {RES_W{1'b0}}},
        {1'b0, 16'd8,     {RES_W{1'b0}}},
        {1'b0, 16'd12,    {RES_W{1'b0}}},
        {1'b0, 16'd25,    {RES_W{1'b0}}},
        {1'b0, 16'd49,    {RES_W{1'b0}}},
        {1'b0, 16'd97,    {RES_W{1'b0}}},
        {1'b0, 16'd143,   {RES_W{1'b0}}},
        {1'b0, 16'd221,   {RES_W{1'b0}}},
        {1'b0, 16'd1024,  {RES_W{1'b0}}},
        {1'b0, 16'd2047,  {RES_W{1'b0}}},
        {1'b0, 16'd3599,  {RES_W{1'b0}}},
        {1'b0, 16'd4087,  {RES_W{1'b0}}},
        // Largest modulus: 3 * 5 * 17 * 257 has no pair, and 6542 primes plus 1 are listed.
        {1'b1, 16'd65535, 1'b0, 16'd0, 16'd0, 13'd0, 13'd0, 14'd6543}
    };

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [ssf_pkg::VAL_W-1:0]    s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [ssf_pkg::M_DATA_W-1:0] m_tdata;

    // Predictor stores: struck-out marks and the ascending survivor list.
    bit                  struck_out [SIEVE_SIZE];
    int unsigned         survivors [LIST_SIZE];

    factor_result_t      pending_results [$];
    int                  failures = 0;
    // While set, neither side idles.
    bit                  no_idle = 1'b0;

    sieve_semiprime_factorizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Sieve the values below the modulus, list the survivors, then take the first
    // list entry that divides the modulus and whose partner is listed as well.
    function automatic factor_result_t factorize(input logic [15:0] modulus);
        int unsigned    lim;
        int unsigned    count;
        int unsigned    a;
        int unsigned    b;
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        int             partner_pos;
        factor_result_t res;
        res   = '0;
        count = 0;
        lim   = (modulus < SIEVE_SIZE) ? modulus : SIEVE_SIZE;
        for (int unsigned v = 0; v < lim; v++) begin
            struck_out[v] = 1'b0;
        end
        if (lim > 0) begin
            struck_out[0] = 1'b1;
        end
        for (int unsigned v = 2; v < lim; v++) begin
            if (!struck_out[v]) begin
                for (int unsigned m = v + v; m < lim; m += v) begin
                    struck_out[m] = 1'b1;
                end
            end
        end
        for (int unsigned v = 0; v < lim && count < LIST_SIZE; v++) begin
            if (!struck_out[v]) begin
                survivors[count] = v;
                count++;
            end
        end
        for (int unsigned p = 0; p < count; p++) begin
            a = survivors[p];
            if (a != 0 && modulus % a == 0) begin
                b           = modulus / a;
                partner_pos = -1;
                lo          = 0;
                hi          = count;
                while (lo < hi && partner_pos < 0) begin
                    mid = lo + (hi - lo) / 2;
                    if (survivors[mid] == b) begin
                        partner_pos = mid;
                    end else if (survivors[mid] < b) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                if (partner_pos >= 0) begin
                    res.found        = 1'b1;
                    res.factor_small = a[ssf_pkg::VAL_W-1:0];
                    res.factor_large = b[ssf_pkg::VAL_W-1:0];
                    res.index_small  = p[ssf_pkg::IDX_W-1:0];
                    res.index_large  = partner_pos[ssf_pkg::IDX_W-1:0];
                    break;
                end
            end
        end
        res.list_count = count[ssf_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Offers one modulus after a random gap and returns at the falling edge after
    // the word was taken, with s_tvalid still high. The caller lowers it.
    task automatic send_modulus(input logic [15:0] modulus, input bit has_answer,
                                input factor_result_t answer);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= modulus;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results.push_back(has_answer ? answer : factorize(modulus));
        @(negedge aclk);
    endtask

    // Holds the sender back until every expected result word has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    // Receiver: stalls a random number of cycles before each word, then takes it.
    initial begin
        factor_result_t want;
        int             stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_tvalid);
            if (pending_results.size() == 0) begin
                $error("result word 0x%0h arrived with no modulus outstanding", m_tdata);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("found",        want.found,        m_tdata[0]);
                check_field("factor_small", want.factor_small, m_tdata[16:1]);
                check_field("factor_large", want.factor_large, m_tdata[32:17]);
                check_field("index_small",  want.index_small,  m_tdata[45:33]);
                check_field("index_large",  want.index_large,  m_tdata[58:46]);
                check_field("list_count",   want.list_count,   m_tdata[72:59]);
            end
            @(negedge aclk);
        end
    end

    // Main stimulus: reset, the directed table, then random moduli.
    initial begin
        int unsigned    pick;
        logic [15:0]    modulus;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_modulus(DIRECTED[i].modulus, DIRECTED[i].has_answer, DIRECTED[i].answer);
        end
        drain_results();

        // Mostly small moduli keep the run short; a share are built as products of
        // two small values so that pairs are found often.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            no_idle = (i >= 30 && i < 45);
            if (i == 60) begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                modulus = 16'($urandom_range(0, 255));
            end else if (pick < 80) begin
                modulus = 16'($urandom_range(2, 31) * $urandom_range(2, 31));
            end else if (pick < 95) begin
                modulus = 16'($urandom_range(256, 2047));
            end else begin
                modulus = 16'($urandom_range(2048, 8191));
            end
            send_modulus(modulus, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        wait (pending_results.size() == 0);
        // Keep running so that a stray extra word would still be caught.
        repeat (500) @(posedge aclk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
